// ===== hdl/olt_pkg.sv =====
`timescale 1ns / 1ps
package olt_pkg;

    typedef enum logic [3:0] {
        ACT_PLACE      = 4'd0,
        ACT_PROBE      = 4'd1,
        ACT_CANCEL     = 4'd2,
        ACT_REPLACE    = 4'd3,
        ACT_ACT_PLACE  = 4'd4,
        ACT_ACT_CANCEL = 4'd5,
        ACT_FILL       = 4'd6,
        ACT_RETIRE     = 4'd7,
        ACT_LIVE_QTY   = 4'd8,
        ACT_CLEAR      = 4'd9
    } action_t;

    typedef enum logic [1:0] {
        KIND_REPLY  = 2'd0,
        KIND_PLACE  = 2'd1,
        KIND_CANCEL = 2'd2,
        KIND_EXPIRY = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_PNEW = 3'd0,
        ST_REST = 3'd1,
        ST_PART = 3'd2,
        ST_PCAN = 3'd3,
        ST_FILL = 3'd4,
        ST_CANC = 3'd5,
        ST_NONE = 3'd6
    } status_t;

    localparam int unsigned ID_W   = 11;
    localparam int unsigned TIME_W = 48;
    localparam int unsigned TOT_W  = 42;
    localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

    // per-order record held in the table memory; vld only counts below the next id
    typedef struct packed {
        logic          vld;
        logic          side;
        logic [31:0]   price;
        logic [31:0]   rem;
        logic [41:0]   filled;
        logic [2:0]    status;
        logic          probe;
        logic          live;
        logic [47:0]   place_eff;
        logic [47:0]   cancel_eff;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] due_time;
        logic [10:0] result_id;
        logic        ok;
        logic [2:0]  status;
        logic [30:0] remaining;
        logic [41:0] side_live_qty;
        logic        last;
    } result_t;

    function automatic logic is_terminal(input logic [2:0] st);
        return (st == ST_FILL) || (st == ST_CANC);
    endfunction

endpackage

// ===== hdl/olt_ram.sv =====
`timescale 1ns / 1ps
module olt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/order_lifecycle_table_core.sv =====
`timescale 1ns / 1ps
// Input word is registered; lookup, read and modify run before the first result word.
// No new action is taken until its result words are taken; a probe place gives its
// second word at once, while replace runs a placement step before its second word.
// Reset (aresetn low, synchronous) sets the next id to one, so every entry reads as
// unknown, and clears both live totals.
// Clear action resets the same state; no memory sweep is needed.
module order_lifecycle_table_core
    import olt_pkg::*;
#(
    parameter int unsigned ORDERS = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // order_id[10:0], side[11], price[43:12], quantity[75:44],
    // now_time[123:76], effective_time[171:124], probe_expiry[219:172]
    input  logic [223:0] s_tdata,
    // action[3:0]
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // due_time[47:0], result_id[58:48], ok[59], status[62:60],
    // remaining[93:63], side_live_qty[135:94]
    output logic [135:0] m_tdata,
    // kind[1:0]
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);
    localparam int unsigned AW = (ORDERS > 1) ? $clog2(ORDERS) : 1;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_OUT1, S_PLACE2, S_OUT2} state_t;

    state_t             state_reg;
    logic [223:0]       in_reg;
    logic [ID_W-1:0]    next_id_reg;
    logic [TOT_W-1:0]   tot_reg [2];
    result_t            res_reg, res2_reg;
    logic               two_reg;

    logic [3:0]        a_act;
    logic [10:0]       a_id;
    logic              a_side;
    logic [31:0]       a_price, a_qty;
    logic [47:0]       a_eff, a_exp;
    assign a_act   = in_reg[3:0];
    assign a_id    = in_reg[14:4];
    assign a_side  = in_reg[15];
    assign a_price = in_reg[47:16];
    assign a_qty   = in_reg[79:48];
    assign a_eff   = in_reg[175:128];
    assign a_exp   = in_reg[223:176];

    // table memory
    logic             we;
    logic [AW-1:0]    waddr, raddr;
    entry_t           wdata, rd;
    logic [ENTRY_W-1:0] rdata;

    olt_ram #(.WIDTH(ENTRY_W), .DEPTH(ORDERS)) u_table (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );
    assign rd = entry_t'(rdata);

    // ids at or above the next id have not been placed since reset or clear
    logic id_in_range, known;
    assign id_in_range = (a_id != '0) && ({21'd0, a_id} <= ORDERS);
    assign raddr = AW'(a_id - 11'd1);
    assign known = id_in_range && (a_id < next_id_reg) && rd.vld;

    logic place_ok;
    assign place_ok = !a_qty[31] && (a_qty != '0) && ({21'd0, next_id_reg} <= ORDERS);

    function automatic logic [TOT_W-1:0] contrib(input entry_t e);
        if (!e.live || e.probe || is_terminal(e.status)) return '0;
        return {10'd0, e.rem};
    endfunction

    function automatic logic [TOT_W-1:0] sat_sub(input logic [TOT_W-1:0] t,
                                                input logic [TOT_W-1:0] c);
        return (t > c) ? t - c : '0;
    endfunction

    function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] t,
                                                input logic [TOT_W-1:0] c);
        return ((TOT_MAX - t) < c) ? TOT_MAX : t + c;
    endfunction

    // execute stage: one entry modified per cycle, only in the execute and second-place states
    entry_t           e_new, p_new;
    result_t          r1, r2;
    logic             e_we, e_two, e_place_now;
    logic [TOT_W-1:0] tot_n [2];
    logic [ID_W-1:0]  nid_n;
    logic [32:0]      diff;
    logic [47:0]      ceff;

    always_comb begin
        e_new = rd;
        e_we = 1'b0;
        e_two = 1'b0;
        e_place_now = 1'b0;
        tot_n[0] = tot_reg[0];
        tot_n[1] = tot_reg[1];
        nid_n = next_id_reg;
        diff = {rd.rem[31], rd.rem} - {a_qty[31], a_qty};
        ceff = a_eff;
        r1 = '0;
        r1.result_id = a_id;
        r1.status = known ? rd.status : ST_NONE;
        r1.remaining = known ? rd.rem[30:0] : '0;
        r1.last = 1'b1;
        r2 = r1;
        case (state_reg == S_PLACE2 ? ACT_PLACE : action_t'(a_act))
            ACT_PLACE, ACT_PROBE: begin
                e_place_now = 1'b1;
            end
            ACT_CANCEL, ACT_REPLACE: begin
                if (known && !is_terminal(rd.status) && rd.status != ST_PCAN) begin
                    if (rd.status == ST_PNEW && a_eff < rd.place_eff) ceff = rd.place_eff;
                    e_new.cancel_eff = ceff;
                    if (rd.status == ST_REST || rd.status == ST_PART) e_new.status = ST_PCAN;
                    e_we = 1'b1;
                    r1.kind = KIND_CANCEL;
                    r1.due_time = ceff;
                    r1.ok = 1'b1;
                    r1.status = e_new.status;
                end
                if (a_act == ACT_REPLACE) begin
                    r1.last = 1'b0;
                    e_two = 1'b1;
                end
            end
            ACT_ACT_PLACE: begin
                if (known && rd.status == ST_PNEW) begin
                    e_new.status = ST_REST;
                    e_we = 1'b1;
                    r1.ok = 1'b1;
                    r1.status = ST_REST;
                end
            end
            ACT_ACT_CANCEL: begin
                if (known && !is_terminal(rd.status)) begin
                    tot_n[rd.side] = sat_sub(tot_reg[rd.side], contrib(rd));
                    e_new.status = ST_CANC;
                    e_new.live = 1'b0;
                    e_we = 1'b1;
                    r1.ok = 1'b1;
                    r1.status = ST_CANC;
                end
            end
            ACT_FILL: begin
                if (known) begin
                    e_new.filled = rd.filled + {{10{a_qty[31]}}, a_qty};
                    if (diff[32] || diff == '0) begin
                        e_new.rem = '0;
                        e_new.status = ST_FILL;
                        e_new.live = 1'b0;
                    end else begin
                        e_new.rem = diff[31] ? 32'h7FFF_FFFF : diff[31:0];
                        if (rd.status == ST_REST) e_new.status = ST_PART;
                    end
                    tot_n[rd.side] = sat_add(sat_sub(tot_reg[rd.side], contrib(rd)),
                                             contrib(e_new));
                    e_we = 1'b1;
                    r1.ok = 1'b1;
                    r1.status = e_new.status;
                    r1.remaining = e_new.rem[30:0];
                end
            end
            ACT_RETIRE: begin
                if (known) begin
                    tot_n[rd.side] = sat_sub(tot_reg[rd.side], contrib(rd));
                    e_new.live = 1'b0;
                    e_new.vld = 1'b0;
                    e_we = 1'b1;
                    r1.ok = 1'b1;
                end
                r1.status = ST_NONE;
                r1.remaining = '0;
            end
            ACT_LIVE_QTY: begin
                r1.result_id = '0;
                r1.ok = 1'b1;
                r1.status = ST_NONE;
                r1.remaining = '0;
            end
            ACT_CLEAR: begin
                tot_n[0] = '0;
                tot_n[1] = '0;
                nid_n = 11'd1;
                r1.result_id = '0;
                r1.ok = 1'b1;
                r1.status = ST_NONE;
                r1.remaining = '0;
            end
            default: begin
                r1.result_id = '0;
                r1.ok = 1'b0;
                r1.status = ST_NONE;
                r1.remaining = '0;
            end
        endcase

        // placement path
        p_new.vld = 1'b1;
        p_new.side = a_side;
        p_new.price = a_price;
        p_new.rem = a_qty;
        p_new.filled = '0;
        p_new.status = ST_PNEW;
        p_new.probe = (state_reg != S_PLACE2) && (a_act == ACT_PROBE);
        p_new.live = 1'b1;
        p_new.place_eff = a_eff;
        p_new.cancel_eff = '0;
        if (e_place_now) begin
            r1 = '0;
            r1.status = ST_NONE;
            r1.last = 1'b1;
            if (place_ok) begin
                nid_n = next_id_reg + 11'd1;
                tot_n[a_side] = sat_add(tot_reg[a_side], contrib(p_new));
                r1.kind = KIND_PLACE;
                r1.due_time = a_eff;
                r1.result_id = next_id_reg;
                r1.ok = 1'b1;
                r1.status = ST_PNEW;
                r1.remaining = a_qty[30:0];
                if (p_new.probe) begin
                    r1.last = 1'b0;
                    e_two = 1'b1;
                    r2 = r1;
                    r2.kind = KIND_EXPIRY;
                    r2.due_time = a_exp;
                    r2.last = 1'b1;
                end
            end
        end
        r1.side_live_qty = tot_n[a_side];
        r2.side_live_qty = tot_n[a_side];
    end

    assign we    = (state_reg == S_EXEC || state_reg == S_PLACE2) &&
                   ((e_place_now && place_ok) || e_we);
    assign waddr = (e_place_now) ? AW'(next_id_reg - 11'd1) : raddr;
    assign wdata = e_place_now ? p_new : e_new;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT1) || (state_reg == S_OUT2);
    assign m_tdata  = {res_reg.side_live_qty, res_reg.remaining, res_reg.status,
                       res_reg.ok, res_reg.result_id, res_reg.due_time};
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            next_id_reg <= 11'd1;
            tot_reg[0]  <= '0;
            tot_reg[1]  <= '0;
            two_reg     <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        in_reg    <= {s_tdata[219:0], s_tuser};
                        state_reg <= S_READ;
                    end
                end
                S_READ: state_reg <= S_EXEC;
                S_EXEC, S_PLACE2: begin
                    tot_reg[0]  <= tot_n[0];
                    tot_reg[1]  <= tot_n[1];
                    next_id_reg <= nid_n;
                    res_reg  <= r1;
                    res2_reg <= r2;
                    two_reg  <= (state_reg == S_EXEC) && e_two;
                    state_reg <= S_OUT1;
                end
                S_OUT1: begin
                    if (m_tready) begin
                        if (!two_reg) begin
                            state_reg <= S_IDLE;
                        end else if (a_act == ACT_REPLACE) begin
                            two_reg   <= 1'b0;
                            state_reg <= S_PLACE2;
                        end else begin
                            two_reg   <= 1'b0;
                            res_reg   <= res2_reg;
                            state_reg <= S_OUT2;
                        end
                    end
                end
                S_OUT2: begin
                    if (m_tready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT1 && !m_tready) |=> $stable(res_reg))
        else $error("result word changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tready && m_tvalid) == 1'b0)
        else $error("input taken while result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (next_id_reg != '0))
        else $error("next id wrapped to zero");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |=> (state_reg == S_EXEC))
        else $error("read not followed by execute");
endmodule
